/* hw/rtl/tpi_pkg.sv */
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types and constants of the timestamped pose interpolation block.
// ----------------------------------------------------------------------------
package tpi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] FN_CLEAR  = 2'd0;
	localparam logic [1:0] FN_APPEND = 2'd1;

	typedef enum logic [2:0] {
		ST_ANSWERED = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_STORED   = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4,
		ST_ORDER    = 3'd5
	} stat_t;

	typedef enum logic [1:0] {
		RA_MID   = 2'd0,
		RA_HI    = 2'd1,
		RA_LO    = 2'd2,
		RA_CLAMP = 2'd3
	} addr_sel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_CLAMP_RD, S_CLAMP_LAT, S_SRCH_RD, S_SRCH_CMP,
		S_HI_RD, S_HI_LAT, S_LO_RD, S_LO_LAT, S_DIV_INIT, S_DIV, S_MUL,
		S_ACC, S_OUT
	} state_t;

	typedef struct packed {
		logic signed [63:0] time_ns;
		logic signed [39:0] lat;
		logic signed [40:0] lon;
		logic signed [25:0] alt;
		logic signed [24:0] roll;
		logic signed [24:0] pitch;
		logic signed [24:0] yaw;
	} sample_t;

	typedef struct packed {
		logic      capture;
		logic      do_clear;
		logic      write;
		logic      set_status;
		stat_t     status;
		logic      srch_init;
		logic      srch_issue;
		logic      srch_step;
		addr_sel_t ra;
		logic      lat_hi;
		logic      lat_lo;
		logic      zero_frac;
		logic      div_init;
		logic      div_step;
		logic      mul;
		logic      acc;
		logic      load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       full;
		logic       order;
		logic       empty;
		logic       clamp;
		logic       srch_more;
		logic       div_full;
		logic       div_last;
		logic       fld_last;
		logic       out_free;
	} sts_t;

endpackage

/* hw/rtl/tpi_ctrl.sv */
// ----------------------------------------------------------------------------
// tpi_ctrl
// Sequencer: decode, table search, division and blend steps.
// ----------------------------------------------------------------------------
module tpi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tpi_pkg::sts_t  sts,
	output tpi_pkg::cmd_t  cmd
);

	tpi_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != tpi_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tpi_pkg::S_IDLE:      if (req_valid) state_d = tpi_pkg::S_DECODE;
			tpi_pkg::S_DECODE: begin
				if (sts.func == tpi_pkg::FN_CLEAR || sts.func == tpi_pkg::FN_APPEND
						|| sts.empty) begin
					state_d = tpi_pkg::S_OUT;
				end else if (sts.clamp) begin
					state_d = tpi_pkg::S_CLAMP_RD;
				end else begin
					state_d = tpi_pkg::S_SRCH_RD;
				end
			end
			tpi_pkg::S_CLAMP_RD:  state_d = tpi_pkg::S_CLAMP_LAT;
			tpi_pkg::S_CLAMP_LAT: state_d = tpi_pkg::S_MUL;
			tpi_pkg::S_SRCH_RD:   state_d = tpi_pkg::S_SRCH_CMP;
			tpi_pkg::S_SRCH_CMP:
				state_d = sts.srch_more ? tpi_pkg::S_SRCH_RD : tpi_pkg::S_HI_RD;
			tpi_pkg::S_HI_RD:     state_d = tpi_pkg::S_HI_LAT;
			tpi_pkg::S_HI_LAT:    state_d = tpi_pkg::S_LO_RD;
			tpi_pkg::S_LO_RD:     state_d = tpi_pkg::S_LO_LAT;
			tpi_pkg::S_LO_LAT:    state_d = tpi_pkg::S_DIV_INIT;
			tpi_pkg::S_DIV_INIT:
				state_d = sts.div_full ? tpi_pkg::S_MUL : tpi_pkg::S_DIV;
			tpi_pkg::S_DIV:       if (sts.div_last) state_d = tpi_pkg::S_MUL;
			tpi_pkg::S_MUL:       state_d = tpi_pkg::S_ACC;
			tpi_pkg::S_ACC:
				state_d = sts.fld_last ? tpi_pkg::S_OUT : tpi_pkg::S_MUL;
			tpi_pkg::S_OUT:       if (sts.out_free) state_d = tpi_pkg::S_IDLE;
			default:              state_d = tpi_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = tpi_pkg::ST_ANSWERED;
		cmd.ra = tpi_pkg::RA_MID;
		unique case (state_q)
			tpi_pkg::S_IDLE:      cmd.capture = req_valid;
			tpi_pkg::S_DECODE: begin
				cmd.set_status = 1'b1;
				if (sts.func == tpi_pkg::FN_CLEAR) begin
					cmd.do_clear = 1'b1;
					cmd.status = tpi_pkg::ST_CLEARED;
				end else if (sts.func == tpi_pkg::FN_APPEND) begin
					if (sts.full) begin
						cmd.status = tpi_pkg::ST_FULL;
					end else if (sts.order) begin
						cmd.status = tpi_pkg::ST_ORDER;
					end else begin
						cmd.status = tpi_pkg::ST_STORED;
						cmd.write = 1'b1;
					end
				end else if (sts.empty) begin
					cmd.status = tpi_pkg::ST_EMPTY;
				end else begin
					cmd.srch_init = 1'b1;
				end
			end
			tpi_pkg::S_CLAMP_RD:  cmd.ra = tpi_pkg::RA_CLAMP;
			// end sample taken as both bounds so every difference is zero
			tpi_pkg::S_CLAMP_LAT: begin
				cmd.lat_hi = 1'b1;
				cmd.lat_lo = 1'b1;
				cmd.zero_frac = 1'b1;
			end
			tpi_pkg::S_SRCH_RD: begin
				cmd.ra = tpi_pkg::RA_MID;
				cmd.srch_issue = 1'b1;
			end
			tpi_pkg::S_SRCH_CMP:  cmd.srch_step = 1'b1;
			tpi_pkg::S_HI_RD:     cmd.ra = tpi_pkg::RA_HI;
			tpi_pkg::S_HI_LAT:    cmd.lat_hi = 1'b1;
			tpi_pkg::S_LO_RD:     cmd.ra = tpi_pkg::RA_LO;
			tpi_pkg::S_LO_LAT:    cmd.lat_lo = 1'b1;
			tpi_pkg::S_DIV_INIT:  cmd.div_init = 1'b1;
			tpi_pkg::S_DIV:       cmd.div_step = 1'b1;
			tpi_pkg::S_MUL:       cmd.mul = 1'b1;
			tpi_pkg::S_ACC:       cmd.acc = 1'b1;
			tpi_pkg::S_OUT:       cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

endmodule

/* hw/rtl/tpi_dp.sv */
// ----------------------------------------------------------------------------
// tpi_dp
// Datapath: sample table, search bounds, fraction divider, blend and result.
// ----------------------------------------------------------------------------
module tpi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tpi_pkg::cmd_t       cmd,
	output tpi_pkg::sts_t       sts,
	input  logic         [1:0]  func,
	input  logic signed  [63:0] time_ns,
	input  logic signed  [39:0] lat_in,
	input  logic signed  [40:0] lon_in,
	input  logic signed  [25:0] alt_in,
	input  logic signed  [24:0] roll_in,
	input  logic signed  [24:0] pitch_in,
	input  logic signed  [24:0] yaw_in,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic         [2:0]  status,
	output logic signed  [39:0] lat_out,
	output logic signed  [40:0] lon_out,
	output logic signed  [25:0] alt_out,
	output logic signed  [25:0] roll_out,
	output logic signed  [25:0] pitch_out,
	output logic signed  [25:0] yaw_out
);

	localparam logic signed [27:0] Ang540 = 28'sd35389440;
	localparam logic signed [27:0] Ang360 = 28'sd23592960;
	localparam logic signed [27:0] Ang720 = 28'sd47185920;
	localparam logic signed [27:0] Ang180 = 28'sd11796480;
	localparam logic [2:0] FldLast = 3'd5;

	function automatic logic signed [25:0] ang_diff(input logic signed [24:0] a,
			input logic signed [24:0] b);
		logic signed [27:0] v;
		v = 28'(b) - 28'(a) + Ang540;
		if (v >= Ang720) v = v - Ang720;
		else if (v >= Ang360) v = v - Ang360;
		v = v - Ang180;
		return v[25:0];
	endfunction

	tpi_pkg::sample_t mem [tpi_pkg::TABLE_DEPTH];
	tpi_pkg::sample_t rd_q, hi_q, lo_q, smp_q;
	logic [tpi_pkg::AW-1:0] addr;

	logic [1:0]             func_q;
	logic [tpi_pkg::CW-1:0] count_q, lo_i_q, hi_i_q, mid_q, mid, lo_m1;
	logic [tpi_pkg::CW-1:0] nlo, nhi;
	logic signed [63:0]     first_q, last_q;
	logic                   lt;

	logic [63:0] r_q, num, den;
	logic [64:0] rs;
	logic [32:0] f_q;
	logic [4:0]  div_cnt_q;
	logic [2:0]  fld_q;

	logic signed [42:0] d_sel;
	logic signed [60:0] p_hi_s1;
	logic signed [59:0] p_lo_s1;
	logic signed [77:0] sum;
	logic signed [45:0] sc;

	tpi_pkg::stat_t     stat_q;
	logic signed [39:0] lat_q;
	logic signed [40:0] lon_q;
	logic signed [25:0] alt_q, roll_q, pitch_q, yaw_q;
	logic               rsp_valid_q;

	// table and read port
	always_comb begin
		mid = lo_i_q + ((hi_i_q - lo_i_q) >> 1);
		lo_m1 = lo_i_q - tpi_pkg::CW'(1);
		unique case (cmd.ra)
			tpi_pkg::RA_MID: addr = mid[tpi_pkg::AW-1:0];
			tpi_pkg::RA_HI:  addr = lo_i_q[tpi_pkg::AW-1:0];
			tpi_pkg::RA_LO:  addr = lo_m1[tpi_pkg::AW-1:0];
			tpi_pkg::RA_CLAMP: begin
				lo_m1 = count_q - tpi_pkg::CW'(1);
				addr = (smp_q.time_ns <= first_q) ? '0 : lo_m1[tpi_pkg::AW-1:0];
			end
			default: addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.write) mem[count_q[tpi_pkg::AW-1:0]] <= smp_q;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.do_clear) begin
			count_q <= '0;
		end else if (cmd.write) begin
			count_q <= count_q + tpi_pkg::CW'(1);
		end
	end

	// item capture, end times, search bounds
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			smp_q <= {time_ns, lat_in, lon_in, alt_in, roll_in, pitch_in, yaw_in};
		end
		if (cmd.write) begin
			if (count_q == '0) first_q <= smp_q.time_ns;
			last_q <= smp_q.time_ns;
		end
		if (cmd.srch_init) begin
			lo_i_q <= '0;
			hi_i_q <= count_q;
		end else if (cmd.srch_step) begin
			lo_i_q <= nlo;
			hi_i_q <= nhi;
		end
		if (cmd.srch_issue) mid_q <= mid;
		if (cmd.lat_hi) hi_q <= rd_q;
		if (cmd.lat_lo) lo_q <= rd_q;
	end

	always_comb begin
		lt = rd_q.time_ns < smp_q.time_ns;
		nlo = lt ? mid_q + tpi_pkg::CW'(1) : lo_i_q;
		nhi = lt ? hi_i_q : mid_q;
	end

	// restoring divider, one quotient bit per cycle
	assign num = smp_q.time_ns - lo_q.time_ns;
	assign den = hi_q.time_ns - lo_q.time_ns;
	assign rs  = {r_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.zero_frac) begin
			f_q <= '0;
		end else if (cmd.div_init) begin
			r_q <= num;
			div_cnt_q <= '0;
			f_q <= (num >= den) ? {1'b1, 32'd0} : '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 5'd1;
			if (rs[64] || rs[63:0] >= den) begin
				r_q <= rs[63:0] - den;
				f_q <= {f_q[31:0], 1'b1};
			end else begin
				r_q <= rs[63:0];
				f_q <= {f_q[31:0], 1'b0};
			end
		end
	end

	// blend: one field per multiply and accumulate step on a shared split multiplier
	always_comb begin
		unique case (fld_q)
			3'd0:    d_sel = 43'(hi_q.lat) - 43'(lo_q.lat);
			3'd1:    d_sel = 43'(hi_q.lon) - 43'(lo_q.lon);
			3'd2:    d_sel = 43'(hi_q.alt) - 43'(lo_q.alt);
			3'd3:    d_sel = 43'(ang_diff(lo_q.roll, hi_q.roll));
			3'd4:    d_sel = 43'(ang_diff(lo_q.pitch, hi_q.pitch));
			default: d_sel = 43'(ang_diff(lo_q.yaw, hi_q.yaw));
		endcase
		sum = (78'(p_hi_s1) <<< 16) + 78'(p_lo_s1);
		sc = sum[77:32];
	end

	always_ff @(posedge clk) begin
		if (cmd.lat_lo) begin
			fld_q <= '0;
		end else if (cmd.acc) begin
			fld_q <= fld_q + 3'd1;
		end
		if (cmd.mul) begin
			p_hi_s1 <= d_sel * $signed({1'b0, f_q[32:16]});
			p_lo_s1 <= d_sel * $signed({1'b0, f_q[15:0]});
		end
		if (cmd.acc) begin
			unique case (fld_q)
				3'd0:    lat_q <= lo_q.lat + sc[39:0];
				3'd1:    lon_q <= lo_q.lon + sc[40:0];
				3'd2:    alt_q <= lo_q.alt + sc[25:0];
				3'd3:    roll_q <= 26'(lo_q.roll) + sc[25:0];
				3'd4:    pitch_q <= 26'(lo_q.pitch) + sc[25:0];
				default: yaw_q <= 26'(lo_q.yaw) + sc[25:0];
			endcase
		end
		if (cmd.set_status) stat_q <= cmd.status;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status <= stat_q;
			if (stat_q == tpi_pkg::ST_ANSWERED) begin
				lat_out <= lat_q;
				lon_out <= lon_q;
				alt_out <= alt_q;
				roll_out <= roll_q;
				pitch_out <= pitch_q;
				yaw_out <= yaw_q;
			end else begin
				lat_out <= '0;
				lon_out <= '0;
				alt_out <= '0;
				roll_out <= '0;
				pitch_out <= '0;
				yaw_out <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.func      = func_q;
		sts.full      = (count_q == tpi_pkg::CW'(tpi_pkg::TABLE_DEPTH));
		sts.order     = (count_q != '0) && (smp_q.time_ns < last_q);
		sts.empty     = (count_q == '0);
		sts.clamp     = (smp_q.time_ns <= first_q) || (smp_q.time_ns >= last_q);
		sts.srch_more = (nlo < nhi);
		sts.div_full  = (num >= den);
		sts.div_last  = (div_cnt_q == 5'd31);
		sts.fld_last  = (fld_q == FldLast);
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

endmodule

/* hw/rtl/timestamped_pose_interpolation.sv */
// ----------------------------------------------------------------------------
// timestamped_pose_interpolation
// Pose sample table with clear, in-order append and interpolated query.
// ----------------------------------------------------------------------------
// One item is worked on at a time and gives one result item. Clear, append
// and an empty-table query go from decode straight to the result register. An
// interpolating query runs the binary search over the table's single
// registered read port, the radix-2 fraction divider and six blend steps on
// one shared multiplier. The table is uninitialised: only the fill count is
// reset, so there is no clearing pass.
module timestamped_pose_interpolation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic        [1:0]  func,
	input  logic signed [63:0] time_ns,
	input  logic signed [39:0] lat_in,
	input  logic signed [40:0] lon_in,
	input  logic signed [25:0] alt_in,
	input  logic signed [24:0] roll_in,
	input  logic signed [24:0] pitch_in,
	input  logic signed [24:0] yaw_in,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic        [2:0]  status,
	output logic signed [39:0] lat_out,
	output logic signed [40:0] lon_out,
	output logic signed [25:0] alt_out,
	output logic signed [25:0] roll_out,
	output logic signed [25:0] pitch_out,
	output logic signed [25:0] yaw_out
);

	tpi_pkg::cmd_t cmd;
	tpi_pkg::sts_t sts;

	tpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.time_ns   (time_ns),
		.lat_in    (lat_in),
		.lon_in    (lon_in),
		.alt_in    (alt_in),
		.roll_in   (roll_in),
		.pitch_in  (pitch_in),
		.yaw_in    (yaw_in),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.lat_out   (lat_out),
		.lon_out   (lon_out),
		.alt_out   (alt_out),
		.roll_out  (roll_out),
		.pitch_out (pitch_out),
		.yaw_out   (yaw_out)
	);

endmodule

/* hw/rtl/tpi_checker.sv */
// ----------------------------------------------------------------------------
// tpi_checker
// Port-level checks of the pose interpolation block, bound to the top level.
// ----------------------------------------------------------------------------
module tpi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic        [2:0]  status,
	input logic signed [39:0] lat_out,
	input logic signed [40:0] lon_out,
	input logic signed [25:0] alt_out,
	input logic signed [25:0] roll_out,
	input logic signed [25:0] pitch_out,
	input logic signed [25:0] yaw_out
);

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input taken twice in a row");

	a_zero_unless_answered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != 3'd0 |-> lat_out == '0 && lon_out == '0
			&& alt_out == '0 && roll_out == '0 && pitch_out == '0 && yaw_out == '0)
		else $error("pose fields not zero on a non-answer status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= 3'd5)
		else $error("status code out of range");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(lat_out))
		else $error("stalled result item changed");

endmodule

bind timestamped_pose_interpolation tpi_checker u_tpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.status    (status),
	.lat_out   (lat_out),
	.lon_out   (lon_out),
	.alt_out   (alt_out),
	.roll_out  (roll_out),
	.pitch_out (pitch_out),
	.yaw_out   (yaw_out)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped pose interpolation testbench
// Drives clear, append and query items through the valid/stall channels, keeps
// its own pose table and interpolation, and checks every result item in order.
// ----------------------------------------------------------------------------

class pose_scoreboard;

	typedef struct {
		tpi_pkg::stat_t    st;
		logic signed [39:0] lat;
		logic signed [40:0] lon;
		logic signed [25:0] alt;
		logic signed [25:0] roll;
		logic signed [25:0] pitch;
		logic signed [25:0] yaw;
	} pose_result_t;

	localparam longint ANG_540 = 64'sd35389440;
	localparam longint ANG_360 = 64'sd23592960;
	localparam longint ANG_180 = 64'sd11796480;

	longint tab_time[tpi_pkg::TABLE_DEPTH];
	longint tab_lat[tpi_pkg::TABLE_DEPTH];
	longint tab_lon[tpi_pkg::TABLE_DEPTH];
	longint tab_alt[tpi_pkg::TABLE_DEPTH];
	longint tab_roll[tpi_pkg::TABLE_DEPTH];
	longint tab_pitch[tpi_pkg::TABLE_DEPTH];
	longint tab_yaw[tpi_pkg::TABLE_DEPTH];
	int fill;
	int errors;
	pose_result_t pending[$];

	function void reset_state();
		fill = 0;
		errors = 0;
	endfunction

	// floor((t - t_lo) * 2^32 / (t_hi - t_lo)), capped at one
	function logic [32:0] time_fraction(logic [63:0] num, logic [63:0] den);
		logic [95:0] q;
		if (num >= den)
			return 33'h1_0000_0000;
		q = {num, 32'd0} / {32'd0, den};
		return q[32:0];
	endfunction

	function longint mix(longint a, longint b, logic [32:0] f);
		logic signed [95:0] d;
		logic signed [95:0] fs;
		logic signed [95:0] pr;
		d = b - a;
		fs = {63'd0, f};
		pr = d * fs;
		return a + longint'(pr >>> 32);
	endfunction

	// shortest way round, not rewrapped
	function longint mix_angle(longint a, longint b, logic [32:0] f);
		longint m;
		m = (b - a + ANG_540) % ANG_360;
		if (m < 0)
			m += ANG_360;
		return mix(a, a + m - ANG_180, f);
	endfunction

	function void note_item(logic [1:0] fn, longint t, longint la, longint lo, longint al,
			longint r, longint p, longint y);
		pose_result_t e;
		int k;
		int h;
		logic [32:0] f;
		e = '{tpi_pkg::ST_ANSWERED, 0, 0, 0, 0, 0, 0};
		if (fn == tpi_pkg::FN_CLEAR) begin
			fill = 0;
			e.st = tpi_pkg::ST_CLEARED;
		end else if (fn == tpi_pkg::FN_APPEND) begin
			if (fill >= tpi_pkg::TABLE_DEPTH)
				e.st = tpi_pkg::ST_FULL;
			else if (fill > 0 && t < tab_time[fill-1])
				e.st = tpi_pkg::ST_ORDER;
			else begin
				tab_time[fill] = t; tab_lat[fill] = la; tab_lon[fill] = lo;
				tab_alt[fill] = al; tab_roll[fill] = r; tab_pitch[fill] = p;
				tab_yaw[fill] = y;
				fill++;
				e.st = tpi_pkg::ST_STORED;
			end
		end else if (fill == 0) begin
			e.st = tpi_pkg::ST_EMPTY;
		end else if (t <= tab_time[0] || t >= tab_time[fill-1]) begin
			k = (t <= tab_time[0]) ? 0 : fill - 1;
			e.lat = tab_lat[k]; e.lon = tab_lon[k]; e.alt = tab_alt[k];
			e.roll = tab_roll[k]; e.pitch = tab_pitch[k]; e.yaw = tab_yaw[k];
		end else begin
			h = 1;
			while (tab_time[h] < t)
				h++;
			k = h - 1;
			f = time_fraction(t - tab_time[k], tab_time[h] - tab_time[k]);
			e.lat = mix(tab_lat[k], tab_lat[h], f);
			e.lon = mix(tab_lon[k], tab_lon[h], f);
			e.alt = mix(tab_alt[k], tab_alt[h], f);
			e.roll = mix_angle(tab_roll[k], tab_roll[h], f);
			e.pitch = mix_angle(tab_pitch[k], tab_pitch[h], f);
			e.yaw = mix_angle(tab_yaw[k], tab_yaw[h], f);
		end
		pending = {pending, e};
	endfunction

	function void check_result(pose_result_t a);
		pose_result_t e;
		if (pending.size() == 0) begin
			$error("result item with nothing expected, status %0d", a.st);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (a.st !== e.st) begin
			$error("status: expected %0d, got %0d", e.st, a.st); errors++;
		end
		if (a.lat !== e.lat) begin
			$error("lat_out: expected %0d, got %0d", e.lat, a.lat); errors++;
		end
		if (a.lon !== e.lon) begin
			$error("lon_out: expected %0d, got %0d", e.lon, a.lon); errors++;
		end
		if (a.alt !== e.alt) begin
			$error("alt_out: expected %0d, got %0d", e.alt, a.alt); errors++;
		end
		if (a.roll !== e.roll) begin
			$error("roll_out: expected %0d, got %0d", e.roll, a.roll); errors++;
		end
		if (a.pitch !== e.pitch) begin
			$error("pitch_out: expected %0d, got %0d", e.pitch, a.pitch); errors++;
		end
		if (a.yaw !== e.yaw) begin
			$error("yaw_out: expected %0d, got %0d", e.yaw, a.yaw); errors++;
		end
	endfunction

endclass

module testbench;

	localparam logic [1:0] FN_QUERY     = 2'd2;
	localparam logic [1:0] FN_QUERY_ALT = 2'd3;
	localparam longint LAT_MAX = 64'sd386547056640;
	localparam longint LON_MAX = 64'sd773094113280;
	localparam longint ALT_MIN = -64'sd1000000;
	localparam longint ALT_MAX = 64'sd20000000;
	localparam longint ANG_MAX = 64'sd11796480;
	localparam longint T_MIN   = 64'h8000_0000_0000_0000;
	localparam longint T_MAX   = 64'h7fff_ffff_ffff_ffff;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic        [1:0]  func = tpi_pkg::FN_CLEAR;
	logic signed [63:0] time_ns = '0;
	logic signed [39:0] lat_in = '0;
	logic signed [40:0] lon_in = '0;
	logic signed [25:0] alt_in = '0;
	logic signed [24:0] roll_in = '0;
	logic signed [24:0] pitch_in = '0;
	logic signed [24:0] yaw_in = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic        [2:0]  status;
	logic signed [39:0] lat_out;
	logic signed [40:0] lon_out;
	logic signed [25:0] alt_out;
	logic signed [25:0] roll_out;
	logic signed [25:0] pitch_out;
	logic signed [25:0] yaw_out;

	pose_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int rotate = 0;
	int sent = 0;
	int send_pct[4] = '{0, 79, 0, 16};
	int recv_pct[4] = '{0, 0, 79, 16};

	timestamped_pose_interpolation u_top (.*);

	always #5 clk = ~clk;

	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_result('{tpi_pkg::stat_t'(status), lat_out, lon_out, alt_out,
				roll_out, pitch_out, yaw_out});
	end

	function automatic longint pick(longint lo, longint hi);
		logic [63:0] span;
		case ($urandom_range(7))
			0: return lo;
			1: return hi;
			default: begin
				span = hi - lo + 1;
				return lo + longint'({$urandom, $urandom} % span);
			end
		endcase
	endfunction

	function automatic longint any_time();
		return longint'({$urandom, $urandom});
	endfunction

	task automatic set_phase(int ph);
		send_idle = send_pct[ph];
		recv_idle = recv_pct[ph];
	endtask

	task automatic send(logic [1:0] fn, longint t, longint la, longint lo, longint al,
			longint r, longint p, longint y);
		while ($urandom_range(99) < send_idle) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		func = fn; time_ns = t; lat_in = la; lon_in = lo; alt_in = al;
		roll_in = r; pitch_in = p; yaw_in = y;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_item(fn, t, la, lo, al, r, p, y);
		sent++;
		if (rotate != 0 && sent % rotate == 0)
			set_phase((sent / rotate) % 4);
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	task automatic append_random(longint t);
		send(tpi_pkg::FN_APPEND, t, pick(-LAT_MAX, LAT_MAX), pick(-LON_MAX, LON_MAX),
			pick(ALT_MIN, ALT_MAX), pick(-ANG_MAX, ANG_MAX), pick(-ANG_MAX, ANG_MAX),
			pick(-ANG_MAX, ANG_MAX));
	endtask

	task automatic query(longint t);
		send($urandom_range(9) == 0 ? FN_QUERY_ALT : FN_QUERY, t,
			pick(-LAT_MAX, LAT_MAX), pick(-LON_MAX, LON_MAX), pick(ALT_MIN, ALT_MAX),
			pick(-ANG_MAX, ANG_MAX), pick(-ANG_MAX, ANG_MAX), pick(-ANG_MAX, ANG_MAX));
	endtask

	// an optional clear, an in-order run of samples and queries around them, some noise
	task automatic sample_run();
		longint times[$];
		longint base;
		int n;
		n = $urandom_range(1, 12);
		if ($urandom_range(4) != 0)
			send(tpi_pkg::FN_CLEAR, any_time(), 0, 0, 0, 0, 0, 0);
		base = pick(-1000000, 1000000);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1))
				times = {times, any_time()};
			else
				times = {times, base + i * $urandom_range(0, 5000)};
		end
		times.sort();
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(7) == 0)
				times[i] = times[i-1];
			append_random(times[i]);
			if ($urandom_range(9) == 0)
				append_random(any_time());
		end
		repeat ($urandom_range(2, 8)) begin
			case ($urandom_range(3))
				0: query(any_time());
				1: query(times[$urandom_range(n - 1)]);
				default: query(pick(times[0], times[n-1]));
			endcase
		end
	endtask

	initial begin
		#10_000_000;
		$display("timestamped_pose_interpolation: mismatch");
		$finish;
	end

	initial begin
		longint last;
		sb.reset_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, extremes, order, equal times, angle wrap
		send(FN_QUERY, 0, 0, 0, 0, 0, 0, 0);
		send(tpi_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send(tpi_pkg::FN_APPEND, T_MIN, -LAT_MAX, -LON_MAX, ALT_MIN, -ANG_MAX, -ANG_MAX,
			-ANG_MAX);
		send(tpi_pkg::FN_APPEND, T_MIN, LAT_MAX, LON_MAX, ALT_MAX, ANG_MAX, ANG_MAX, ANG_MAX);
		send(tpi_pkg::FN_APPEND, 0, LAT_MAX, -LON_MAX, ALT_MAX, -ANG_MAX, ANG_MAX, 0);
		send(tpi_pkg::FN_APPEND, -5, 1, 1, 1, 1, 1, 1);
		send(tpi_pkg::FN_APPEND, 1000, -LAT_MAX, LON_MAX, ALT_MIN, 11141120, -11141120, 0);
		send(tpi_pkg::FN_APPEND, 2000, 0, 0, 0, -11141120, 11141120, ANG_MAX);
		send(tpi_pkg::FN_APPEND, T_MAX, LAT_MAX, LON_MAX, ALT_MAX, ANG_MAX, -ANG_MAX,
			-ANG_MAX);
		send(FN_QUERY, T_MIN, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, T_MAX, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, -64'sd4611686018427387904, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, 0, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, 1, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, 1500, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY_ALT, 1999, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, 64'sd4611686018427387904, 0, 0, 0, 0, 0, 0);
		send(tpi_pkg::FN_CLEAR, T_MAX, 0, 0, 0, 0, 0, 0);
		send(tpi_pkg::FN_APPEND, 7, 5, -5, 5, -5, 5, -5);
		send(FN_QUERY, 6, 0, 0, 0, 0, 0, 0);
		send(FN_QUERY, 8, 0, 0, 0, 0, 0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			set_phase(ph);
			repeat (2) sample_run();
		end

		// fill to the top, then full drops and deep searches
		rotate = 150;
		send(tpi_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		last = pick(T_MIN, 0);
		for (int i = 0; i < tpi_pkg::TABLE_DEPTH; i++) begin
			last += $urandom_range(0, 1 << $urandom_range(0, 30));
			append_random(last);
		end
		repeat (3) append_random(last + 1);
		repeat (30) query(pick(T_MIN, last + 10));
		rotate = 0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("timestamped_pose_interpolation: match");
		else
			$display("timestamped_pose_interpolation: mismatch");
		$finish;
	end

endmodule
